>>> hdl/bpht_pkg.sv
`timescale 1ns / 1ps
package bpht_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int PROBE_LIMIT = 32;
  localparam int KEY_WIDTH   = 32;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(PROBE_LIMIT + 1);
  localparam int ID_W   = 32;
  localparam int SLOT_W = 13;
  localparam int ENT_W  = KEY_WIDTH + ID_W;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [ID_W-1:0]      id;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   eviction_count;
    logic [ID_W-1:0]   entry_id;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic              hit;
    logic              valid_res;
  } res_t;

  // Two xor-shift rounds, then the low bits select the start slot.
  function automatic logic [IDX_W-1:0] hash_start(input logic [KEY_WIDTH-1:0] k);
    logic [KEY_WIDTH-1:0] h;
    h = k ^ (k >> 7);
    h = h ^ (h >> 15);
    return h[IDX_W-1:0];
  endfunction

endpackage

>>> hdl/bpht_ram.sv
`timescale 1ns / 1ps
module bpht_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hdl/bpht_ctrl.sv
`timescale 1ns / 1ps
module bpht_ctrl
  import bpht_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  cmd_e                 req_cmd_i,
  input  logic [KEY_WIDTH-1:0] req_key_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output res_t                 res_o
);

  state_e state_q, state_d;

  logic [IDX_W-1:0]     clr_cnt_q;
  logic [CNT_W-1:0]     issue_cnt_q, proc_cnt_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  cmd_e                 cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [IDX_W-1:0]     start_q;
  logic                 have_empty_q;
  logic [IDX_W-1:0]     empty_q, oldest_q;
  logic [ID_W-1:0]      oldest_id_q;
  logic [ID_W-1:0]      serial_q, evict_q;
  res_t                 res_q;
  logic                 wr_pend_q;
  logic [IDX_W-1:0]     wr_addr_q;
  entry_t               wr_data_q;

  logic                 clr_done;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_raw;
  entry_t               rd_ent;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;
  logic                 cur_hit, last_rd, take_old, probe_end;
  logic                 nx_have_empty;
  logic [IDX_W-1:0]     nx_empty, nx_oldest, tgt;
  logic [ID_W-1:0]      nx_old_id, serial_inc, evict_inc;
  logic                 ev;
  res_t                 fin_res;
  logic                 fin_wr_pend;
  logic [IDX_W-1:0]     fin_wr_addr;
  entry_t               fin_wr_data;
  logic                 trivial;

  bpht_ram #(
    .DATA_W(ENT_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_raw)
  );

  assign rd_ent   = entry_t'(rd_raw);
  assign clr_done = (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1));
  assign rd_addr  = start_q + IDX_W'(issue_cnt_q);
  assign trivial  = (req_key_i == '0) || (req_cmd_i == CMD_NONE);

  // Fold the returning slot into the running empty and oldest candidates.
  assign cur_hit       = rd_vld_q && (rd_ent.key == key_q);
  assign last_rd       = rd_vld_q && (proc_cnt_q == CNT_W'(PROBE_LIMIT - 1));
  assign probe_end     = (state_q == ST_PROBE) && (cur_hit || last_rd);
  assign take_old      = (proc_cnt_q == '0) || (rd_ent.id < oldest_id_q);
  assign nx_oldest     = take_old ? rd_idx_q : oldest_q;
  assign nx_old_id     = take_old ? rd_ent.id : oldest_id_q;
  assign nx_have_empty = have_empty_q || (rd_ent.key == '0);
  assign nx_empty      = have_empty_q ? empty_q : rd_idx_q;
  assign tgt           = nx_have_empty ? nx_empty : nx_oldest;
  assign ev            = !nx_have_empty;
  assign serial_inc    = serial_q + ID_W'(1);
  assign evict_inc     = evict_q + ID_W'(1);

  always_comb begin
    fin_res                = '0;
    fin_res.eviction_count = evict_q;
    fin_wr_pend            = 1'b0;
    fin_wr_addr            = rd_idx_q;
    fin_wr_data            = '0;
    if (cur_hit) begin
      fin_res.valid_res = 1'b1;
      fin_res.hit       = 1'b1;
      fin_res.slot      = SLOT_W'(rd_idx_q);
      if (cmd_q == CMD_INVAL) begin
        fin_wr_pend = 1'b1;
      end else begin
        fin_res.entry_id = rd_ent.id;
      end
    end else if (cmd_q == CMD_INSERT) begin
      // With no empty slot in the window, the oldest one is always occupied.
      fin_res.valid_res      = 1'b1;
      fin_res.evicted        = ev;
      fin_res.slot           = SLOT_W'(tgt);
      fin_res.entry_id       = serial_inc;
      fin_res.eviction_count = ev ? evict_inc : evict_q;
      fin_wr_pend            = 1'b1;
      fin_wr_addr            = tgt;
      fin_wr_data.key        = key_q;
      fin_wr_data.id         = serial_inc;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = trivial ? ST_FIN : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_q;
    mem_wdata   = wr_data_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
      end
      ST_PROBE: begin
        rd_en = (issue_cnt_q < CNT_W'(PROBE_LIMIT)) && !probe_end;
      end
      ST_FIN: begin
        res_valid_o = 1'b1;
        mem_we      = res_ready_i && wr_pend_q;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      issue_cnt_q  <= '0;
      proc_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      have_empty_q <= 1'b0;
      serial_q     <= '0;
      evict_q      <= '0;
      wr_pend_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if (req_valid_i && req_ready_o) begin
        issue_cnt_q  <= '0;
        proc_cnt_q   <= '0;
        have_empty_q <= 1'b0;
        wr_pend_q    <= 1'b0;
      end
      if (rd_en) begin
        issue_cnt_q <= issue_cnt_q + CNT_W'(1);
      end
      if ((state_q == ST_PROBE) && rd_vld_q) begin
        proc_cnt_q   <= proc_cnt_q + CNT_W'(1);
        have_empty_q <= nx_have_empty;
      end
      if (probe_end) begin
        wr_pend_q <= fin_wr_pend;
        if (!cur_hit && (cmd_q == CMD_INSERT)) begin
          serial_q <= serial_inc;
          if (ev) begin
            evict_q <= evict_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr;
    if (req_valid_i && req_ready_o) begin
      cmd_q                <= req_cmd_i;
      key_q                <= req_key_i;
      start_q              <= hash_start(req_key_i);
      res_q                <= '0;
      res_q.eviction_count <= evict_q;
    end
    if ((state_q == ST_PROBE) && rd_vld_q) begin
      oldest_q    <= nx_oldest;
      oldest_id_q <= nx_old_id;
      empty_q     <= nx_empty;
    end
    if (probe_end) begin
      res_q     <= fin_res;
      wr_addr_q <= fin_wr_addr;
      wr_data_q <= fin_wr_data;
    end
  end

endmodule

>>> hdl/bounded_probe_hash_tracker_unit.sv
`timescale 1ns / 1ps
// Address-keyed tracking table with 8192 slots held in one synchronous memory. After
// reset the block writes zero to every slot of the memory before it raises
// s_axis_tready_o. Each command then walks its probe window of 32 slots one memory
// read per cycle, stopping at the first key match: a request is accepted, issues its
// probe reads, then writes back and hands over its result; an early hit ends the probe.
// A zero key or the unused command skips the probe and goes straight to its result.
// Exactly one result transaction follows every request, and a finished result sits
// in an output register so the next request can be taken while it waits.
module bounded_probe_hash_tracker_unit
  import bpht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] key
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // [12:0] slot, [44:13] entry_id, [76:45] eviction_count
  output logic [2:0]  m_axis_tuser_o   // [0] valid_res, [1] hit, [2] evicted
);

  logic res_valid, res_ready;
  res_t res;
  logic out_vld_q;
  res_t out_q;

  bpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .req_cmd_i  (cmd_e'(s_axis_tuser_i)),
    .req_key_i  (s_axis_tdata_i[KEY_WIDTH-1:0]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = {out_q.evicted, out_q.hit, out_q.valid_res};
  assign m_axis_tdata_o  = {3'b000, out_q.eviction_count, out_q.entry_id, out_q.slot};

endmodule

>>> verif/bpht_result_checker.sv
`timescale 1ns / 1ps
module bpht_result_checker
  import bpht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [31:0] req_key_i,    // [31:0] key
  input  logic [1:0]  req_cmd_i,    // [1:0] cmd
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [79:0] res_data_i,   // [12:0] slot, [44:13] entry_id, [76:45] eviction_count
  input  logic [2:0]  res_flags_i,  // [0] valid_res, [1] hit, [2] evicted
  output int          mismatches_o,
  output int          outstanding_o
);

  logic [KEY_WIDTH-1:0] slot_key_q [TABLE_DEPTH];
  logic [ID_W-1:0]      slot_id_q  [TABLE_DEPTH];
  logic [ID_W-1:0]      serial_q;
  logic [ID_W-1:0]      evict_total_q;
  res_t                 pending_results [$];
  res_t                 want_r;
  int                   errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic logic [IDX_W-1:0] window_start(input logic [31:0] k);
    logic [31:0] mix;
    mix = k ^ {7'd0, k[31:7]};
    mix = mix ^ {15'd0, mix[31:15]};
    return mix[IDX_W-1:0];
  endfunction

  // Applies one request to the shadow table and returns the result it causes.
  function automatic res_t track_request(input cmd_e cmd, input logic [31:0] key);
    res_t             r;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] oldest;
    logic [IDX_W-1:0] empty_idx;
    bit               have_empty;
    r = '0;
    r.eviction_count = evict_total_q;
    if (key == '0 || cmd == CMD_NONE) begin
      return r;
    end
    base       = window_start(key);
    oldest     = base;
    empty_idx  = base;
    have_empty = 1'b0;
    for (int n = 0; n < PROBE_LIMIT; n++) begin
      idx = IDX_W'(int'(base) + n);
      if (slot_key_q[idx] == key) begin
        r.valid_res = 1'b1;
        r.hit       = 1'b1;
        r.slot      = SLOT_W'(idx);
        if (cmd == CMD_INVAL) begin
          slot_key_q[idx] = '0;
          slot_id_q[idx]  = '0;
        end else begin
          r.entry_id = slot_id_q[idx];
        end
        return r;
      end
      if (n == 0 || slot_id_q[idx] < slot_id_q[oldest]) begin
        oldest = idx;
      end
      if (slot_key_q[idx] == '0 && !have_empty) begin
        empty_idx  = idx;
        have_empty = 1'b1;
      end
    end
    if (cmd != CMD_INSERT) begin
      return r;
    end
    if (!have_empty) begin
      empty_idx = oldest;
      evict_total_q++;
      r.evicted = 1'b1;
    end
    serial_q++;
    slot_key_q[empty_idx] = key;
    slot_id_q[empty_idx]  = serial_q;
    r.valid_res      = 1'b1;
    r.slot           = SLOT_W'(empty_idx);
    r.entry_id       = serial_q;
    r.eviction_count = evict_total_q;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_key_q[i] = '0;
        slot_id_q[i]  = '0;
      end
      serial_q      = '0;
      evict_total_q = '0;
      pending_results.delete();
    end else begin
      // Results are checked before the request of the same edge is predicted,
      // since that result can only belong to an older transaction.
      if (res_valid_i && res_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          want_r = pending_results.pop_front();
          check_field("valid_res", 32'(res_flags_i[0]), 32'(want_r.valid_res));
          check_field("hit", 32'(res_flags_i[1]), 32'(want_r.hit));
          check_field("evicted", 32'(res_flags_i[2]), 32'(want_r.evicted));
          check_field("slot", 32'(res_data_i[12:0]), 32'(want_r.slot));
          check_field("entry_id", res_data_i[44:13], want_r.entry_id);
          check_field("eviction_count", res_data_i[76:45], want_r.eviction_count);
          check_field("tdata padding", 32'(res_data_i[79:77]), '0);
        end
      end
      if (req_valid_i && req_ready_i) begin
        pending_results.push_back(track_request(cmd_e'(req_cmd_i), req_key_i));
      end
    end
    outstanding_o <= pending_results.size();
    mismatches_o  <= errors;
  end

endmodule

>>> verif/bounded_probe_hash_tracker_unit_tb.sv
`timescale 1ns / 1ps
module bounded_probe_hash_tracker_unit_tb;
  import bpht_pkg::*;

  localparam int REQUESTS     = 1550;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 40;
  localparam int CLUSTERS     = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [31:0] s_data;
  logic [1:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [79:0] m_data;
  logic [2:0]  m_user;

  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;
  bit          hold_request = 1'b0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;
  logic [31:0] recent_keys [$];
  int unsigned cluster_base [CLUSTERS] = '{0, 8180, 8188, 1234, 5000, 5020};

  bounded_probe_hash_tracker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  bpht_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_valid),
    .req_ready_i   (s_ready),
    .req_key_i     (s_data),
    .req_cmd_i     (s_user),
    .res_valid_i   (m_valid),
    .res_ready_i   (m_ready),
    .res_data_i    (m_data),
    .res_flags_i   (m_user),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Builds a random key whose probe window starts at the given slot by running
  // both xor-shift rounds backwards from a chosen hash value.
  function automatic logic [31:0] key_for_slot(input logic [12:0] slot);
    logic [31:0] h;
    logic [31:0] g;
    logic [31:0] k;
    do begin
      h       = $urandom();
      h[12:0] = slot;
      g = h ^ (h >> 15) ^ (h >> 30);
      k = g ^ (g >> 7) ^ (g >> 14) ^ (g >> 21) ^ (g >> 28);
    end while (k == '0);
    return k;
  endfunction

  task automatic send_request(input cmd_e cmd, input logic [31:0] key);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= key;
    s_user  <= cmd;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("bounded_probe_hash_tracker_unit_tb: errors");
    $finish;
  end

  initial begin : result_sink
    int stall;
    int handled;
    handled = 0;
    m_ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = recv_steady ? 0 : $urandom_range(0, 10);
      // A long hold-off lets the block fill its output register and stall its input.
      if (hold_request) begin
        stall += HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
      handled++;
      if (handled % 50 == 0) begin
        recv_steady = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] wrap_a;
    logic [31:0] wrap_b;
    logic [31:0] wrap_c;
    logic [31:0] key;
    cmd_e        cmd;
    int          useful;
    int          roll;
    int          pick;
    int unsigned base;

    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= CMD_LOOKUP;
    rst_ni  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero key, the unused command, all-ones key through its whole life, and a
    // window that wraps past the last slot with a hole punched into it.
    wrap_a = key_for_slot(13'd8191);
    wrap_b = key_for_slot(13'd8191);
    wrap_c = key_for_slot(13'd8191);
    send_request(CMD_LOOKUP, 32'h0);
    send_request(CMD_INSERT, 32'h0);
    send_request(CMD_INVAL, 32'h0);
    send_request(CMD_NONE, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h0000_0001);
    send_request(CMD_INVAL, 32'hFFFF_FFFF);
    send_request(CMD_INVAL, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, wrap_a);
    send_request(CMD_INSERT, wrap_b);
    send_request(CMD_INSERT, wrap_c);
    send_request(CMD_INVAL, wrap_b);
    send_request(CMD_LOOKUP, wrap_c);
    send_request(CMD_INSERT, key_for_slot(13'd8191));
    send_request(CMD_INVAL, 32'h0000_0001);
    send_request(CMD_NONE, 32'h0);

    // Mostly traffic aimed at a few crowded windows, some overlapping and some
    // wrapping, so that hits, holes and evictions of the oldest entry all occur.
    useful = 0;
    while (useful < REQUESTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        cmd = cmd_e'($urandom_range(0, 3));
        key = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom();
      end else begin
        base = cluster_base[$urandom_range(0, CLUSTERS - 1)];
        if (recent_keys.size() > 0 && $urandom_range(0, 1) == 1) begin
          key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end else begin
          key = key_for_slot(13'(base + $urandom_range(0, 5)));
        end
        pick = $urandom_range(0, 9);
        cmd  = (pick < 5) ? CMD_INSERT : (pick < 8) ? CMD_LOOKUP : CMD_INVAL;
      end
      if (cmd == CMD_INSERT && key != '0) begin
        recent_keys.push_back(key);
        if (recent_keys.size() > 150) begin
          void'(recent_keys.pop_front());
        end
      end
      send_request(cmd, key);
      if (key != '0 && cmd != CMD_NONE) begin
        useful++;
        if (useful % 60 == 0) begin
          send_steady = ($urandom_range(0, 3) == 0);
        end
        if (useful == 400 || useful == 1100) begin
          hold_request = 1'b1;
          send_steady  = 1'b1;
        end
      end
    end
    s_valid <= 1'b0;

    // The outstanding count only takes in the last request after its accepting edge.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bounded_probe_hash_tracker_unit_tb: clean");
    end else begin
      $display("bounded_probe_hash_tracker_unit_tb: errors");
    end
    $finish;
  end

endmodule
